/* design/mbss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbss_pkg
// Shared widths, register indexes and item types of the masked byte
// signature scan.
// ----------------------------------------------------------------------------
package mbss_pkg;

	localparam int DATA_W       = 8;
	localparam int FIELD_ADDR_W = 48;
	localparam int SIG_LEN_W    = 6;
	localparam int SIG_IDX_W    = 5;
	localparam int MASK_W       = 32;
	localparam int CFG_W        = 64;
	localparam int CFG_IDX_W    = 3;
	localparam int SIG_ALL_W    = 256;

	localparam logic [SIG_LEN_W-1:0] SIG_LENGTH_RESET = 6'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SIG_A,
		CFG_SIG_B,
		CFG_SIG_C,
		CFG_SIG_D,
		CFG_CARE_MASK,
		CFG_SIG_LENGTH
	} cfg_index_t;

	typedef struct packed {
		logic                    scan_end;
		logic                    range_start;
		logic [FIELD_ADDR_W-1:0] byte_address;
		logic [DATA_W-1:0]       data_byte;
	} item_t;

	typedef struct packed {
		logic                    found;
		logic [FIELD_ADDR_W-1:0] match_address;
	} result_t;

endpackage

/* design/mbss_sig_align.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbss_sig_align
// Configuration registers, plus a registered copy of the signature and care
// mask reordered so that lane j lines up with window entry j.
// ----------------------------------------------------------------------------
module mbss_sig_align #(
	parameter int MAX_SIG_LEN = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [mbss_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [mbss_pkg::CFG_W-1:0]            cfg_wdata,
	output logic [MAX_SIG_LEN*mbss_pkg::DATA_W-1:0] aligned_sig,
	output logic [MAX_SIG_LEN-1:0]                aligned_care,
	output logic [$clog2(MAX_SIG_LEN+1)-1:0]      eff_len
);

	localparam int LEN_W = $clog2(MAX_SIG_LEN + 1);

	logic [mbss_pkg::CFG_W-1:0]     sig_a_q, sig_b_q, sig_c_q, sig_d_q;
	logic [mbss_pkg::MASK_W-1:0]    care_mask_q;
	logic [mbss_pkg::SIG_LEN_W-1:0] sig_length_q;

	logic [mbss_pkg::SIG_ALL_W-1:0]       sig_all;
	logic [mbss_pkg::SIG_LEN_W-1:0]       len6;
	logic [mbss_pkg::SIG_LEN_W-1:0]       idx6;
	logic [MAX_SIG_LEN*mbss_pkg::DATA_W-1:0] sig_c;
	logic [MAX_SIG_LEN-1:0]               care_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sig_a_q      <= '0;
			sig_b_q      <= '0;
			sig_c_q      <= '0;
			sig_d_q      <= '0;
			care_mask_q  <= '0;
			sig_length_q <= mbss_pkg::SIG_LENGTH_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				mbss_pkg::CFG_SIG_A:      sig_a_q      <= cfg_wdata;
				mbss_pkg::CFG_SIG_B:      sig_b_q      <= cfg_wdata;
				mbss_pkg::CFG_SIG_C:      sig_c_q      <= cfg_wdata;
				mbss_pkg::CFG_SIG_D:      sig_d_q      <= cfg_wdata;
				mbss_pkg::CFG_CARE_MASK:  care_mask_q  <= cfg_wdata[mbss_pkg::MASK_W-1:0];
				mbss_pkg::CFG_SIG_LENGTH: sig_length_q <= cfg_wdata[mbss_pkg::SIG_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Lane j compares window entry j (newest first) with signature byte len-1-j.
	always_comb begin
		sig_all = {sig_d_q, sig_c_q, sig_b_q, sig_a_q};
		if (sig_length_q == '0)
			len6 = 6'd1;
		else if (sig_length_q > mbss_pkg::SIG_LEN_W'(MAX_SIG_LEN))
			len6 = mbss_pkg::SIG_LEN_W'(MAX_SIG_LEN);
		else
			len6 = sig_length_q;
		idx6   = '0;
		sig_c  = '0;
		care_c = '0;
		for (int j = 0; j < MAX_SIG_LEN; j++) begin
			idx6 = len6 - 6'd1 - mbss_pkg::SIG_LEN_W'(j);
			if (mbss_pkg::SIG_LEN_W'(j) < len6) begin
				sig_c[j*mbss_pkg::DATA_W +: mbss_pkg::DATA_W] =
					sig_all[{idx6[mbss_pkg::SIG_IDX_W-1:0], 3'b000} +: mbss_pkg::DATA_W];
				care_c[j] = care_mask_q[idx6[mbss_pkg::SIG_IDX_W-1:0]];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aligned_sig  <= '0;
			aligned_care <= '0;
			eff_len      <= LEN_W'(1);
		end else begin
			aligned_sig  <= sig_c;
			aligned_care <= care_c;
			eff_len      <= len6[LEN_W-1:0];
		end
	end

endmodule

/* design/mbss_scan_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbss_scan_core
// Byte window, fill count and match flag, the parallel masked compare and
// the result register.
// ----------------------------------------------------------------------------
module mbss_scan_core #(
	parameter int MAX_SIG_LEN = 32,
	parameter int ADDR_BITS   = 48
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    advance,
	input  mbss_pkg::item_t                         item,
	input  logic [MAX_SIG_LEN*mbss_pkg::DATA_W-1:0] aligned_sig,
	input  logic [MAX_SIG_LEN-1:0]                  aligned_care,
	input  logic [$clog2(MAX_SIG_LEN+1)-1:0]        eff_len,
	input  logic                                    out_ready,
	output logic                                    out_valid,
	output mbss_pkg::result_t                       result
);

	localparam int LEN_W = $clog2(MAX_SIG_LEN + 1);
	localparam int AW    = (ADDR_BITS < mbss_pkg::FIELD_ADDR_W) ? ADDR_BITS
	                                                            : mbss_pkg::FIELD_ADDR_W;

	logic [mbss_pkg::DATA_W-1:0] win_q    [MAX_SIG_LEN];
	logic [mbss_pkg::DATA_W-1:0] win_next [MAX_SIG_LEN];
	logic [LEN_W-1:0]            fill_q, fill_base, fill_next, len_m1;
	logic                        done_q, out_valid_q;
	logic [MAX_SIG_LEN-1:0]      pos_ok;
	logic                        hit, emit;
	logic [AW-1:0]               first_addr;
	mbss_pkg::result_t           result_q;

	always_comb begin
		win_next[0] = item.data_byte;
		for (int k = 1; k < MAX_SIG_LEN; k++)
			win_next[k] = win_q[k-1];
		// range start empties the window before this byte enters
		fill_base = item.range_start ? '0 : fill_q;
		fill_next = (fill_base < LEN_W'(MAX_SIG_LEN)) ? fill_base + LEN_W'(1) : fill_base;
		for (int j = 0; j < MAX_SIG_LEN; j++)
			pos_ok[j] = !aligned_care[j] ||
			            (win_next[j] == aligned_sig[j*mbss_pkg::DATA_W +: mbss_pkg::DATA_W]);
		hit        = !done_q && (fill_next >= eff_len) && (&pos_ok);
		emit       = hit || (item.scan_end && !done_q);
		len_m1     = eff_len - LEN_W'(1);
		first_addr = item.byte_address[AW-1:0] - AW'(len_m1);
	end

	always_ff @(posedge clk) begin
		if (advance)
			for (int k = 0; k < MAX_SIG_LEN; k++)
				win_q[k] <= win_next[k];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			done_q <= 1'b0;
		end else if (advance) begin
			fill_q <= item.scan_end ? '0 : fill_next;
			done_q <= item.scan_end ? 1'b0 : (done_q | hit);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance && emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			result_q.found         <= hit;
			result_q.match_address <= hit ? mbss_pkg::FIELD_ADDR_W'(first_addr) : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

endmodule

/* design/masked_byte_signature_scan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_byte_signature_scan
// Streams memory bytes and reports the first place where a masked byte
// signature of up to MAX_SIG_LEN bytes matches inside one readable range.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one memory byte per transaction; s_tuser marks the first
//   byte of a readable range, s_tlast marks the last byte of the scan.
//   Output stream: at most one transaction per scan. m_tuser = 1 gives the
//   address of the first byte of the first match; m_tuser = 0 with a zero
//   address says the scan ended with no match. After a match, bytes are
//   taken and dropped until s_tlast.
//   Throughput is one byte per clock unless a stalled output fills both
//   registers; the window compare for all lanes is a single level of byte
//   comparators and an AND tree. The byte that causes a result passes the
//   input register, then the result register, before that result is on
//   m_tdata.
//   Reset clears the window count, match flag, both valid flags and loads
//   the default configuration (length 1, all wildcards).
//   A stalled output holds its result; the input register still fills, and
//   s_tready drops only while both registers are full and m_tready is low.
//   Configuration writes take effect via the config, then aligned registers.
// ----------------------------------------------------------------------------
module masked_byte_signature_scan #(
	parameter int MAX_SIG_LEN = 32,
	parameter int ADDR_BITS   = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // [7:0] data_byte, [55:8] byte_address
	input  logic        s_tuser,  // [0] range_start
	input  logic        s_tlast,  // scan_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // [47:0] match_address
	output logic        m_tuser   // [0] found
);

	logic                                    valid_s1;
	mbss_pkg::item_t                         item_s1;
	logic                                    advance;
	logic [MAX_SIG_LEN*mbss_pkg::DATA_W-1:0] aligned_sig;
	logic [MAX_SIG_LEN-1:0]                  aligned_care;
	logic [$clog2(MAX_SIG_LEN+1)-1:0]        eff_len;
	mbss_pkg::result_t                       result;

	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tvalid && s_tready)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.data_byte    <= s_tdata[7:0];
			item_s1.byte_address <= s_tdata[55:8];
			item_s1.range_start  <= s_tuser;
			item_s1.scan_end     <= s_tlast;
		end
	end

	mbss_sig_align #(
		.MAX_SIG_LEN (MAX_SIG_LEN)
	) u_align (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.aligned_sig  (aligned_sig),
		.aligned_care (aligned_care),
		.eff_len      (eff_len)
	);

	mbss_scan_core #(
		.MAX_SIG_LEN (MAX_SIG_LEN),
		.ADDR_BITS   (ADDR_BITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.item         (item_s1),
		.aligned_sig  (aligned_sig),
		.aligned_care (aligned_care),
		.eff_len      (eff_len),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.result       (result)
	);

	assign m_tdata = result.match_address;
	assign m_tuser = result.found;

endmodule

/* design/mbss_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbss_checker
// Port-level checks of the signature scan, bound to the top level.
// ----------------------------------------------------------------------------
module mbss_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic        m_tuser
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// a not-found result carries a zero address
	a_nf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("not-found result with nonzero address");

	// an empty output register never blocks the input
	a_ready_free: assert property (@(posedge clk)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// no result once reset has been seen at an edge
	a_rst_quiet: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("result valid during reset");

	// a result appears only after an input transaction
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result without an input transaction");

endmodule

bind masked_byte_signature_scan mbss_checker u_mbss_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

/* bench/tb_masked_byte_signature_scan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_masked_byte_signature_scan
// Streams scans of memory bytes through the masked signature scanner and
// checks every result against a cycle-free predictor of the same scan. The
// stimulus consists of short directed scans, then random phases with fresh
// signature, mask and length settings. The phases plant signatures inside
// and across range breaks and add random idling on both stream sides.
// ----------------------------------------------------------------------------
module tb_masked_byte_signature_scan;

	localparam int STALL_LIMIT  = 2000;
	localparam int RANDOM_ITEMS = 1450;
	localparam int DRAIN_CYCLES = 6;

	class scan_scoreboard;
		logic [63:0]       sig_word [4];
		logic [31:0]       care;
		logic [5:0]        len_reg;
		logic [7:0]        win [32];
		int unsigned       fill;
		bit                matched;
		mbss_pkg::result_t expected_q [$];
		int                errors;

		function new();
			foreach (sig_word[k]) sig_word[k] = '0;
			care    = '0;
			len_reg = mbss_pkg::SIG_LENGTH_RESET;
			matched = 1'b0;
			errors  = 0;
			clear_win();
		endfunction

		function void clear_win();
			foreach (win[k]) win[k] = '0;
			fill = 0;
		endfunction

		function void write_reg(mbss_pkg::cfg_index_t idx, logic [63:0] v);
			case (idx)
				mbss_pkg::CFG_SIG_A:      sig_word[0] = v;
				mbss_pkg::CFG_SIG_B:      sig_word[1] = v;
				mbss_pkg::CFG_SIG_C:      sig_word[2] = v;
				mbss_pkg::CFG_SIG_D:      sig_word[3] = v;
				mbss_pkg::CFG_CARE_MASK:  care = v[31:0];
				mbss_pkg::CFG_SIG_LENGTH: len_reg = v[5:0];
				default: ;
			endcase
		endfunction

		function int unsigned active_len();
			if (len_reg == 0) return 1;
			if (len_reg > 32) return 32;
			return len_reg;
		endfunction

		function logic [7:0] sig_at(int unsigned i);
			logic [63:0] w;
			w = sig_word[i >> 3];
			return w[(i % 8) * 8 +: 8];
		endfunction

		// Append one expected result at the tail.
		function void add_expected(mbss_pkg::result_t r);
			expected_q.insert(expected_q.size(), r);
		endfunction

		// Shift one accepted byte into the window and queue what it causes.
		function void note_item(mbss_pkg::item_t it);
			int unsigned       n;
			bit                hit;
			mbss_pkg::result_t r;
			n = active_len();
			if (it.range_start) clear_win();
			for (int k = 31; k > 0; k--) win[k] = win[k-1];
			win[0] = it.data_byte;
			if (fill < 32) fill++;
			if (!matched && fill >= n) begin
				hit = 1'b1;
				for (int k = 0; k < n; k++) begin
					if (care[k] && win[n-1-k] != sig_at(k)) hit = 1'b0;
				end
				if (hit) begin
					r.found         = 1'b1;
					r.match_address = it.byte_address - 48'(n - 1);
					add_expected(r);
					matched = 1'b1;
				end
			end
			if (it.scan_end) begin
				if (!matched) begin
					r.found         = 1'b0;
					r.match_address = '0;
					add_expected(r);
				end
				clear_win();
				matched = 1'b0;
			end
		endfunction

		task report_mismatch(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(logic found, logic [47:0] addr);
			mbss_pkg::result_t e;
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result found=%0b addr=%h", found, addr));
				return;
			end
			e = expected_q.pop_front();
			if (found !== e.found)
				report_mismatch($sformatf("found %0b, want %0b", found, e.found));
			if (addr !== e.match_address)
				report_mismatch($sformatf("match_address %h, want %h", addr, e.match_address));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;   // [7:0] data_byte, [55:8] byte_address
	logic        s_tuser = 1'b0; // [0] range_start
	logic        s_tlast = 1'b0; // scan_end
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;        // [47:0] match_address
	logic        m_tuser;        // [0] found

	scan_scoreboard sb;
	int idle_pct     = 35;
	int sent         = 0;
	int stall_cycles = 0;

	masked_byte_signature_scan dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (m_tvalid === 1'b1 && m_tready)
			sb.check_result(m_tuser, m_tdata);
		m_tready <= ($urandom_range(0, 99) >= idle_pct);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic send_item(mbss_pkg::item_t it);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata  <= {it.byte_address, it.data_byte};
		s_tuser  <= it.range_start;
		s_tlast  <= it.scan_end;
		do @(posedge clk); while (s_tready !== 1'b1);
		sb.note_item(it);
		sent++;
		if ($urandom_range(0, 99) < idle_pct) begin
			gap = $urandom_range(1, 2);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_byte(logic [7:0] d, logic [47:0] a, logic rs, logic last);
		mbss_pkg::item_t it;
		it.data_byte    = d;
		it.byte_address = a;
		it.range_start  = rs;
		it.scan_end     = last;
		send_item(it);
	endtask

	// Hold off the sender until every result is out, then let the pipe settle.
	task automatic drain(int extra);
		s_tvalid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic put_reg(mbss_pkg::cfg_index_t idx, logic [63:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		sb.write_reg(idx, v);
	endtask

	task automatic load_config(logic [63:0] a, logic [63:0] b, logic [63:0] c,
	                           logic [63:0] d, logic [31:0] mask, logic [5:0] len);
		put_reg(mbss_pkg::CFG_SIG_A, a);
		put_reg(mbss_pkg::CFG_SIG_B, b);
		put_reg(mbss_pkg::CFG_SIG_C, c);
		put_reg(mbss_pkg::CFG_SIG_D, d);
		put_reg(mbss_pkg::CFG_CARE_MASK, {32'h0, mask});
		put_reg(mbss_pkg::CFG_SIG_LENGTH, {58'h0, len});
		cfg_we <= 1'b0;
		// writes land via the config registers, then the aligned registers
		repeat (4) @(posedge clk);
	endtask

	task automatic run_scan(int unsigned body, bit plant);
		mbss_pkg::item_t seq [0:127];
		logic [47:0]     addr;
		int unsigned     n, pos;
		int              r;
		n = sb.active_len();
		r = $urandom_range(0, 99);
		if (r < 10) addr = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 40));
		else if (r < 20) addr = 48'($urandom_range(0, 8));
		else addr = {16'($urandom), $urandom};
		for (int j = 0; j < body; j++) begin
			seq[j].range_start = (j == 0) ? ($urandom_range(0, 99) < 80)
			                              : ($urandom_range(0, 99) < 5);
			if (j > 0 && seq[j].range_start && $urandom_range(0, 1))
				addr = {16'($urandom), $urandom};
			seq[j].data_byte = ($urandom_range(0, 99) < 30) ?
				sb.sig_at($urandom_range(0, n - 1)) : 8'($urandom);
			seq[j].byte_address = addr;
			seq[j].scan_end     = (j == body - 1);
			addr = addr + 48'd1;
		end
		if (plant && body >= n) begin
			pos = $urandom_range(0, body - n);
			for (int j = 0; j < n; j++)
				if (sb.care[j]) seq[pos+j].data_byte = sb.sig_at(j);
			// most plants stay inside one range, the rest may straddle a break
			if ($urandom_range(0, 99) < 75)
				for (int j = 1; j < n; j++) seq[pos+j].range_start = 1'b0;
		end
		for (int j = 0; j < body; j++) send_item(seq[j]);
	endtask

	initial begin
		logic [63:0] w [4];
		logic [31:0] mask;
		logic [5:0]  len;
		int          phase, scans, r;
		int unsigned n, body;

		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset setting: length one, all wildcards, so the first byte matches.
		send_byte(8'h00, 48'h0, 1'b1, 1'b0);
		send_byte(8'hFF, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b1);
		drain(DRAIN_CYCLES);

		load_config(64'hFFFF_FFFF_FFFF_BBAA, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'h0,
		            32'h0000_0003, 6'd2);
		// match whose first byte sits at the top of the address space
		send_byte(8'hAA, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0);
		send_byte(8'hBB, 48'h0, 1'b0, 1'b0);
		send_byte(8'hAA, 48'h1, 1'b0, 1'b1);
		// signature split by a range break
		send_byte(8'hAA, 48'h10, 1'b1, 1'b0);
		send_byte(8'hBB, 48'h11, 1'b1, 1'b0);
		send_byte(8'h00, 48'h12, 1'b0, 1'b1);
		// match on the last byte of the scan
		send_byte(8'hAA, 48'h8000_0000_0000, 1'b1, 1'b0);
		send_byte(8'hBB, 48'h8000_0000_0001, 1'b0, 1'b1);
		// scan ends before the window fills
		send_byte(8'hBB, 48'h7FFF_FFFF_FFFF, 1'b1, 1'b1);
		drain(DRAIN_CYCLES);

		load_config(64'h0000_0000_0000_005A, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF,
		            64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 6'd0);
		send_byte(8'h5A, 48'h1234_5678_9ABC, 1'b1, 1'b1);
		send_byte(8'h5B, 48'h1234_5678_9ABD, 1'b0, 1'b1);
		drain(DRAIN_CYCLES);

		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			foreach (w[k]) w[k] = {$urandom, $urandom};
			r = $urandom_range(0, 99);
			if (r < 40) mask = '1;
			else if (r < 75) mask = $urandom;
			else if (r < 85) mask = '0;
			else mask = $urandom & $urandom;
			r = $urandom_range(0, 99);
			if (r < 60) len = 6'($urandom_range(1, 6));
			else if (r < 80) len = 6'($urandom_range(7, 32));
			else len = 6'($urandom_range(0, 63));
			case (phase)
				0: begin len = 6'd32; mask = '1; end
				1: begin len = 6'd63; mask = '0; end
				2: len = 6'd1;
				3: len = 6'd33;
				4: begin foreach (w[k]) w[k] = '1; len = 6'd32; mask = '1; end
				5: begin foreach (w[k]) w[k] = '0; len = 6'd8; mask = '1; end
				default: ;
			endcase
			load_config(w[0], w[1], w[2], w[3], mask, len);
			idle_pct = (phase == 3) ? 0 : 35;
			n = sb.active_len();
			scans = $urandom_range(3, 8);
			for (int s = 0; s < scans && sent < RANDOM_ITEMS; s++) begin
				if (phase == 2 && s == scans / 2) drain(0);
				body = ($urandom_range(0, 99) < 12) ? $urandom_range(1, n)
				                                    : n + $urandom_range(0, 24);
				run_scan(body, $urandom_range(0, 99) < 70);
			end
			drain(DRAIN_CYCLES);
			phase++;
		end
		idle_pct = 35;

		drain(10);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
